// ----- src/sfa_pkg.sv -----
// Shared types, codes and helper functions for the steering block.
package sfa_pkg;

    localparam int W  = 32;
    localparam int F  = 16;
    localparam int CW = 31;

    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;

    localparam logic OPCODE_LOAD = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEEK   = 2'd0,
        MODE_FLEE   = 2'd1,
        MODE_ARRIVE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_STEER_MODE     = 3'd0,
        CFG_MAX_SPEED      = 3'd1,
        CFG_MAX_ACCEL      = 3'd2,
        CFG_TARGET_RADIUS  = 3'd3,
        CFG_SLOW_RADIUS    = 3'd4,
        CFG_TIME_TO_TARGET = 3'd5,
        CFG_STOP_SPEED     = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NEXT,
        ST_LEN_X, ST_LEN_Y, ST_LEN_ADD, ST_LEN_WAIT,
        ST_SC_X, ST_SC_XD, ST_SC_XW, ST_SC_Y, ST_SC_YD, ST_SC_YW,
        ST_MD_MUL, ST_MD_DIV, ST_MD_WAIT,
        ST_EU0, ST_EU1, ST_EU2, ST_EU3, ST_EU4,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        PH_DIST, PH_TS, PH_TV, PH_EX, PH_EY, PH_ALEN, PH_ACC, PH_SP, PH_SCL, PH_SP2
    } t_phase;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    function automatic logic signed [31:0] sat_word(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > WMAX) r = 32'sh7fffffff;
        else if (v < WMIN) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // product scaled down by the fraction, rounded toward zero
    function automatic logic signed [63:0] frac_down(input logic signed [63:0] v);
        logic signed [63:0] m;
        logic signed [63:0] r;
        if (v < 0) begin
            m = -v;
            r = -(m >> F);
        end else begin
            r = v >> F;
        end
        return r;
    endfunction

endpackage

// ----- src/sfa_mul.sv -----
// Registered signed multiplier shared by the sequencer.
module sfa_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [63:0] o_p
);
    logic signed [65:0] w_full;
    logic signed [63:0] r_p;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_full[63:0];
    end

    assign o_p = r_p;
endmodule

// ----- src/sfa_iter.sv -----
// Bit-serial signed divider and integer square root on one shared datapath.
module sfa_iter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfa_pkg::t_iter_req     i_req,
    input  logic [63:0]            i_num,
    input  logic [31:0]            i_den,
    output sfa_pkg::t_iter_stat    o_stat,
    output logic signed [63:0]     o_quot,
    output logic [31:0]            o_root
);
    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [34:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_den;

    logic [32:0] w_drem;
    logic        w_dge;
    logic [35:0] w_srem;
    logic [35:0] w_strial;
    logic        w_sge;

    always_comb begin
        w_drem   = {r_rem[31:0], r_a[63]};
        w_dge    = w_drem >= {1'b0, r_den};
        w_srem   = {r_rem[33:0], r_a[63:62]};
        w_strial = {2'b00, r_q[31:0], 2'b01};
        w_sge    = w_srem >= w_strial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.is_sqrt ? 6'd31 : 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.is_sqrt;
            r_neg  <= !i_req.is_sqrt && i_num[63];
            r_a    <= (!i_req.is_sqrt && i_num[63]) ? (64'd0 - i_num) : i_num;
            r_rem  <= '0;
            r_q    <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (r_sqrt) begin
                r_a   <= {r_a[61:0], 2'b00};
                r_rem <= w_sge ? 35'(w_srem - w_strial) : 35'(w_srem);
                r_q   <= {r_q[62:0], w_sge};
            end else begin
                r_a   <= {r_a[62:0], 1'b0};
                r_rem <= w_dge ? 35'(w_drem - {1'b0, r_den}) : 35'(w_drem);
                r_q   <= {r_q[62:0], w_dge};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_neg ? -$signed(r_q) : $signed(r_q);
    assign o_root      = r_q[31:0];
endmodule

// ----- src/steering_seek_flee_arrive_step.sv -----
// Top level: agent state, configuration registers and the steering sequencer.
//
// Keeps one agent's position and velocity (signed Q16.16) and steps it.
// Input channel: i_in_valid / o_in_stall carries one word, either a tick
// (target point and time step) or a load (position and velocity).
// Output channel: o_out_valid / i_out_stall carries the state after the word
// and the acceleration used (zero on a load).
// Configuration: i_cfg_we writes register i_cfg_addr with i_cfg_data.
// One word is worked on at a time; o_in_stall stays high until its result is
// placed in the output register. Ticks run as a chain of subroutines on one
// multiplier and one bit-serial divide/square-root unit: lengths, two-component
// scales and divides, each run to completion before the next one starts.
// If the receiver stalls, the finished result waits in the output register
// and the next word is held off only when a second result is ready.
// Reset (synchronous) clears position and velocity, loads the register
// defaults and empties the output register.
module steering_seek_flee_arrive_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic [30:0]        i_delta_time,
    input  logic signed [31:0] i_load_pos_x,
    input  logic signed [31:0] i_load_pos_y,
    input  logic signed [31:0] i_load_vel_x,
    input  logic signed [31:0] i_load_vel_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y
);
    // configuration
    sfa_pkg::t_mode r_mode;
    logic [30:0] r_max_speed, r_max_accel, r_target_radius;
    logic [30:0] r_slow_radius, r_ttt, r_stop_speed;

    // agent state
    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;

    // sequencer
    sfa_pkg::t_state r_state, n_state;
    sfa_pkg::t_phase r_phase;

    // working registers
    logic signed [32:0] r_dx, r_dy, r_vecx, r_vecy, r_resx, r_resy, r_tvy;
    logic signed [32:0] r_ma, r_mb;
    logic [31:0]        r_len, r_dist, r_den;
    logic [30:0]        r_mag, r_dt;
    logic [63:0]        r_acc;
    logic signed [63:0] r_q;
    logic signed [31:0] r_ax, r_ay, r_nvx;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_ax, r_o_ay;

    // shared units
    logic signed [32:0]   w_ma, w_mb;
    logic signed [63:0]   w_p;
    sfa_pkg::t_iter_req   w_req;
    sfa_pkg::t_iter_stat  w_stat;
    logic [63:0]          w_inum;
    logic [31:0]          w_iden;
    logic signed [63:0]   w_quot;
    logic [31:0]          w_root;

    logic w_accept, w_out_free;
    logic signed [31:0] w_step_sat;

    assign w_accept   = i_in_valid && (r_state == sfa_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    sfa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    sfa_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (w_inum),
        .i_den   (w_iden),
        .o_stat  (w_stat),
        .o_quot  (w_quot),
        .o_root  (w_root)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfa_pkg::ST_IDLE:
                if (w_accept)
                    n_state = (i_opcode == sfa_pkg::OPCODE_LOAD) ? sfa_pkg::ST_DONE
                                                                 : sfa_pkg::ST_LEN_X;
            sfa_pkg::ST_LEN_X:   n_state = sfa_pkg::ST_LEN_Y;
            sfa_pkg::ST_LEN_Y:   n_state = sfa_pkg::ST_LEN_ADD;
            sfa_pkg::ST_LEN_ADD: n_state = sfa_pkg::ST_LEN_WAIT;
            sfa_pkg::ST_LEN_WAIT:
                if (w_stat.done) n_state = sfa_pkg::ST_NEXT;
            sfa_pkg::ST_SC_X:
                n_state = (r_len == 32'd0) ? sfa_pkg::ST_NEXT : sfa_pkg::ST_SC_XD;
            sfa_pkg::ST_SC_XD:   n_state = sfa_pkg::ST_SC_XW;
            sfa_pkg::ST_SC_XW:
                if (w_stat.done) n_state = sfa_pkg::ST_SC_Y;
            sfa_pkg::ST_SC_Y:    n_state = sfa_pkg::ST_SC_YD;
            sfa_pkg::ST_SC_YD:   n_state = sfa_pkg::ST_SC_YW;
            sfa_pkg::ST_SC_YW:
                if (w_stat.done) n_state = sfa_pkg::ST_NEXT;
            sfa_pkg::ST_MD_MUL:  n_state = sfa_pkg::ST_MD_DIV;
            sfa_pkg::ST_MD_DIV:  n_state = sfa_pkg::ST_MD_WAIT;
            sfa_pkg::ST_MD_WAIT:
                if (w_stat.done) n_state = sfa_pkg::ST_NEXT;
            sfa_pkg::ST_EU0:     n_state = sfa_pkg::ST_EU1;
            sfa_pkg::ST_EU1:     n_state = sfa_pkg::ST_EU2;
            sfa_pkg::ST_EU2:     n_state = sfa_pkg::ST_EU3;
            sfa_pkg::ST_EU3:     n_state = sfa_pkg::ST_EU4;
            sfa_pkg::ST_EU4:     n_state = sfa_pkg::ST_LEN_X;
            sfa_pkg::ST_DONE:
                if (w_out_free) n_state = sfa_pkg::ST_IDLE;
            sfa_pkg::ST_NEXT: begin
                case (r_phase)
                    sfa_pkg::PH_DIST: begin
                        case (r_mode)
                            sfa_pkg::MODE_SEEK, sfa_pkg::MODE_FLEE:
                                n_state = sfa_pkg::ST_SC_X;
                            sfa_pkg::MODE_ARRIVE:
                                if (r_len < {1'b0, r_target_radius} ||
                                    r_len > {1'b0, r_slow_radius} ||
                                    r_slow_radius == 31'd0)
                                    n_state = sfa_pkg::ST_NEXT;
                                else
                                    n_state = sfa_pkg::ST_MD_MUL;
                            default: n_state = sfa_pkg::ST_EU0;
                        endcase
                    end
                    sfa_pkg::PH_TS:   n_state = sfa_pkg::ST_SC_X;
                    sfa_pkg::PH_TV:   n_state = sfa_pkg::ST_MD_MUL;
                    sfa_pkg::PH_EX:   n_state = sfa_pkg::ST_MD_MUL;
                    sfa_pkg::PH_EY:   n_state = sfa_pkg::ST_LEN_X;
                    sfa_pkg::PH_ALEN:
                        n_state = (r_len > {1'b0, r_max_accel}) ? sfa_pkg::ST_SC_X
                                                                : sfa_pkg::ST_EU0;
                    sfa_pkg::PH_ACC:  n_state = sfa_pkg::ST_EU0;
                    sfa_pkg::PH_SP:
                        n_state = (r_len > {1'b0, r_max_speed}) ? sfa_pkg::ST_SC_X
                                                                : sfa_pkg::ST_DONE;
                    sfa_pkg::PH_SCL:  n_state = sfa_pkg::ST_LEN_X;
                    sfa_pkg::PH_SP2:  n_state = sfa_pkg::ST_DONE;
                    default:          n_state = sfa_pkg::ST_IDLE;
                endcase
            end
            default: n_state = sfa_pkg::ST_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        w_ma          = '0;
        w_mb          = '0;
        w_req.start   = 1'b0;
        w_req.is_sqrt = 1'b0;
        w_inum        = w_p;
        w_iden        = r_len;
        case (r_state)
            sfa_pkg::ST_LEN_X: begin
                w_ma = r_vecx;
                w_mb = r_vecx;
            end
            sfa_pkg::ST_LEN_Y: begin
                w_ma = r_vecy;
                w_mb = r_vecy;
            end
            sfa_pkg::ST_LEN_ADD: begin
                w_req.start   = 1'b1;
                w_req.is_sqrt = 1'b1;
                w_inum        = r_acc + w_p;
            end
            sfa_pkg::ST_SC_X: begin
                w_ma = r_vecx;
                w_mb = {2'b00, r_mag};
            end
            sfa_pkg::ST_SC_Y: begin
                w_ma = r_vecy;
                w_mb = {2'b00, r_mag};
            end
            sfa_pkg::ST_SC_XD, sfa_pkg::ST_SC_YD: w_req.start = 1'b1;
            sfa_pkg::ST_MD_MUL: begin
                w_ma = r_ma;
                w_mb = r_mb;
            end
            sfa_pkg::ST_MD_DIV: begin
                w_req.start = 1'b1;
                w_iden      = r_den;
            end
            sfa_pkg::ST_EU0: begin
                w_ma = {r_vel_x[31], r_vel_x};
                w_mb = {2'b00, r_dt};
            end
            sfa_pkg::ST_EU1: begin
                w_ma = {r_vel_y[31], r_vel_y};
                w_mb = {2'b00, r_dt};
            end
            sfa_pkg::ST_EU2: begin
                w_ma = {r_ax[31], r_ax};
                w_mb = {2'b00, r_dt};
            end
            sfa_pkg::ST_EU3: begin
                w_ma = {r_ay[31], r_ay};
                w_mb = {2'b00, r_dt};
            end
            default: ;
        endcase
    end

    // saturated base + product scaled to the fraction, for the Euler steps
    always_comb begin
        case (r_state)
            sfa_pkg::ST_EU1:
                w_step_sat = sfa_pkg::sat_word(64'(r_pos_x) + sfa_pkg::frac_down(w_p));
            sfa_pkg::ST_EU2:
                w_step_sat = sfa_pkg::sat_word(64'(r_pos_y) + sfa_pkg::frac_down(w_p));
            sfa_pkg::ST_EU3:
                w_step_sat = sfa_pkg::sat_word(64'(r_vel_x) + sfa_pkg::frac_down(w_p));
            default:
                w_step_sat = sfa_pkg::sat_word(64'(r_vel_y) + sfa_pkg::frac_down(w_p));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= sfa_pkg::ST_IDLE;
            r_mode          <= sfa_pkg::MODE_ARRIVE;
            r_max_speed     <= 31'd524288;
            r_max_accel     <= 31'd131072;
            r_target_radius <= 31'd0;
            r_slow_radius   <= 31'd655360;
            r_ttt           <= 31'd65536;
            r_stop_speed    <= 31'd0;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_vel_x         <= '0;
            r_vel_y         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (sfa_pkg::t_cfg_idx'(i_cfg_addr))
                    sfa_pkg::CFG_STEER_MODE:     r_mode <= sfa_pkg::t_mode'(i_cfg_data[1:0]);
                    sfa_pkg::CFG_MAX_SPEED:      r_max_speed     <= i_cfg_data;
                    sfa_pkg::CFG_MAX_ACCEL:      r_max_accel     <= i_cfg_data;
                    sfa_pkg::CFG_TARGET_RADIUS:  r_target_radius <= i_cfg_data;
                    sfa_pkg::CFG_SLOW_RADIUS:    r_slow_radius   <= i_cfg_data;
                    sfa_pkg::CFG_TIME_TO_TARGET: r_ttt           <= i_cfg_data;
                    sfa_pkg::CFG_STOP_SPEED:     r_stop_speed    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == sfa_pkg::ST_DONE && w_out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;

            case (r_state)
                sfa_pkg::ST_IDLE:
                    if (w_accept && i_opcode == sfa_pkg::OPCODE_LOAD) begin
                        r_pos_x <= i_load_pos_x;
                        r_pos_y <= i_load_pos_y;
                        r_vel_x <= i_load_vel_x;
                        r_vel_y <= i_load_vel_y;
                    end
                sfa_pkg::ST_EU1: r_pos_x <= w_step_sat;
                sfa_pkg::ST_EU2: r_pos_y <= w_step_sat;
                sfa_pkg::ST_NEXT:
                    if ((r_phase == sfa_pkg::PH_SP && r_len <= {1'b0, r_max_speed}) ||
                        r_phase == sfa_pkg::PH_SP2) begin
                        if (r_len < {1'b0, r_stop_speed}) begin
                            r_vel_x <= '0;
                            r_vel_y <= '0;
                        end else begin
                            r_vel_x <= r_vecx[31:0];
                            r_vel_y <= r_vecy[31:0];
                        end
                    end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            sfa_pkg::ST_IDLE:
                if (w_accept) begin
                    r_ax <= '0;
                    r_ay <= '0;
                    r_dt <= i_delta_time;
                    r_phase <= sfa_pkg::PH_DIST;
                    r_dx   <= 33'(sfa_pkg::sat_word(64'(i_target_x) - 64'(r_pos_x)));
                    r_dy   <= 33'(sfa_pkg::sat_word(64'(i_target_y) - 64'(r_pos_y)));
                    r_vecx <= 33'(sfa_pkg::sat_word(64'(i_target_x) - 64'(r_pos_x)));
                    r_vecy <= 33'(sfa_pkg::sat_word(64'(i_target_y) - 64'(r_pos_y)));
                end
            sfa_pkg::ST_LEN_Y: r_acc <= w_p;
            sfa_pkg::ST_LEN_WAIT:
                if (w_stat.done) r_len <= w_root;
            sfa_pkg::ST_SC_X:
                if (r_len == 32'd0) begin
                    r_resx <= '0;
                    r_resy <= '0;
                end
            sfa_pkg::ST_SC_XW:
                if (w_stat.done) r_resx <= w_quot[32:0];
            sfa_pkg::ST_SC_YW:
                if (w_stat.done) r_resy <= w_quot[32:0];
            sfa_pkg::ST_MD_WAIT:
                if (w_stat.done) r_q <= w_quot;
            sfa_pkg::ST_EU3: r_nvx <= w_step_sat;
            sfa_pkg::ST_EU4: begin
                r_vecx  <= {r_nvx[31], r_nvx};
                r_vecy  <= {w_step_sat[31], w_step_sat};
                r_phase <= sfa_pkg::PH_SP;
            end
            sfa_pkg::ST_NEXT: begin
                case (r_phase)
                    sfa_pkg::PH_DIST: begin
                        r_dist <= r_len;
                        r_mag  <= r_max_accel;
                        case (r_mode)
                            sfa_pkg::MODE_SEEK: r_phase <= sfa_pkg::PH_ACC;
                            sfa_pkg::MODE_FLEE: begin
                                r_vecx  <= -r_dx;
                                r_vecy  <= -r_dy;
                                r_phase <= sfa_pkg::PH_ACC;
                            end
                            sfa_pkg::MODE_ARRIVE: begin
                                r_phase <= sfa_pkg::PH_TS;
                                r_ma    <= {2'b00, r_max_speed};
                                r_mb    <= {1'b0, r_len};
                                r_den   <= {1'b0, r_slow_radius};
                                if (r_len < {1'b0, r_target_radius})
                                    r_q <= '0;
                                else if (r_len > {1'b0, r_slow_radius})
                                    r_q <= 64'(r_max_speed);
                                else
                                    r_q <= '0;
                            end
                            default: begin
                                r_ax <= '0;
                                r_ay <= '0;
                            end
                        endcase
                    end
                    sfa_pkg::PH_TS: begin
                        // target velocity: offset scaled to the target speed
                        r_len   <= r_dist;
                        r_mag   <= r_q[30:0];
                        r_phase <= sfa_pkg::PH_TV;
                    end
                    sfa_pkg::PH_TV: begin
                        r_tvy   <= r_resy;
                        r_ma    <= r_resx - {r_vel_x[31], r_vel_x};
                        r_mb    <= 33'(1) <<< sfa_pkg::F;
                        r_den   <= (r_ttt == 31'd0) ? 32'd1 : {1'b0, r_ttt};
                        r_phase <= sfa_pkg::PH_EX;
                    end
                    sfa_pkg::PH_EX: begin
                        r_ax    <= sfa_pkg::sat_word(r_q);
                        r_ma    <= r_tvy - {r_vel_y[31], r_vel_y};
                        r_phase <= sfa_pkg::PH_EY;
                    end
                    sfa_pkg::PH_EY: begin
                        r_ay    <= sfa_pkg::sat_word(r_q);
                        r_vecx  <= {r_ax[31], r_ax};
                        r_vecy  <= 33'(sfa_pkg::sat_word(r_q));
                        r_phase <= sfa_pkg::PH_ALEN;
                    end
                    sfa_pkg::PH_ALEN: begin
                        r_mag   <= r_max_accel;
                        r_phase <= sfa_pkg::PH_ACC;
                    end
                    sfa_pkg::PH_ACC: begin
                        r_ax <= r_resx[31:0];
                        r_ay <= r_resy[31:0];
                    end
                    sfa_pkg::PH_SP: begin
                        r_mag   <= r_max_speed;
                        r_phase <= sfa_pkg::PH_SCL;
                    end
                    sfa_pkg::PH_SCL: begin
                        r_vecx  <= r_resx;
                        r_vecy  <= r_resy;
                        r_phase <= sfa_pkg::PH_SP2;
                    end
                    default: ;
                endcase
            end
            sfa_pkg::ST_DONE:
                if (w_out_free) begin
                    r_o_px <= r_pos_x;
                    r_o_py <= r_pos_y;
                    r_o_vx <= r_vel_x;
                    r_o_vy <= r_vel_y;
                    r_o_ax <= r_ax;
                    r_o_ay <= r_ay;
                end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != sfa_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_pos_x = r_o_px;
    assign o_out_pos_y = r_o_py;
    assign o_out_vel_x = r_o_vx;
    assign o_out_vel_y = r_o_vy;
    assign o_accel_x   = r_o_ax;
    assign o_accel_y   = r_o_ay;

`ifndef SYNTHESIS
    a_iter_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_stat.busy)
        else $error("shared unit started while busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while one is in work");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == sfa_pkg::ST_LEN_WAIT || r_state == sfa_pkg::ST_SC_XW ||
                         r_state == sfa_pkg::ST_SC_YW || r_state == sfa_pkg::ST_MD_WAIT))
        else $error("shared unit finished with no state waiting on it");
`endif
endmodule

// ----- tb/tb_steering_seek_flee_arrive_step.sv -----
// Self-checking testbench for the seek / flee / arrive steering step block.
module tb_steering_seek_flee_arrive_step;

    localparam longint ONE_Q = 65536;
    localparam longint TIMEOUT_CYCLES = 8000000;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic               opcode;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic [30:0]        dt;
        logic signed [31:0] lpx;
        logic signed [31:0] lpy;
        logic signed [31:0] lvx;
        logic signed [31:0] lvy;
    } t_word;

    // 0 pos_x, 1 pos_y, 2 vel_x, 3 vel_y, 4 accel_x, 5 accel_y
    typedef logic [5:0][31:0] t_agent_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_addr;
    logic [30:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_opcode;
    logic signed [31:0] i_target_x;
    logic signed [31:0] i_target_y;
    logic [30:0]        i_delta_time;
    logic signed [31:0] i_load_pos_x;
    logic signed [31:0] i_load_pos_y;
    logic signed [31:0] i_load_vel_x;
    logic signed [31:0] i_load_vel_y;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_out_pos_x;
    logic signed [31:0] o_out_pos_y;
    logic signed [31:0] o_out_vel_x;
    logic signed [31:0] o_out_vel_y;
    logic signed [31:0] o_accel_x;
    logic signed [31:0] o_accel_y;

    steering_seek_flee_arrive_step i_dut (.*);

    // predictor copy of the configuration and agent state
    sfa_pkg::t_mode  ag_mode;
    longint unsigned ag_max_speed, ag_max_accel, ag_tgt_radius;
    longint unsigned ag_slow_radius, ag_ttt, ag_stop_speed;
    longint          ag_px, ag_py, ag_vx, ag_vy;

    t_agent_out expected_states[$];
    int         mismatches = 0;
    int         snd_idle = 0;
    int         rcv_idle = 0;
    longint     cycles = 0;
    string      field_names[6] = '{"pos_x", "pos_y", "vel_x", "vel_y", "accel_x", "accel_y"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(input longint x, input longint y);
        longint unsigned ax;
        longint unsigned ay;
        ax = (x < 0) ? longint'(-x) : x;
        ay = (y < 0) ? longint'(-y) : y;
        return int_sqrt(ax * ax + ay * ay);
    endfunction

    task automatic rescale(input longint x, input longint y, input longint unsigned len,
                           input longint unsigned m, output longint ox, output longint oy);
        if (len == 0) begin
            ox = 0;
            oy = 0;
        end else begin
            ox = x * longint'(m) / longint'(len);
            oy = y * longint'(m) / longint'(len);
        end
    endtask

    task automatic step_agent(input t_word w, output t_agent_out res);
        longint ax, ay, dt, dx, dy, vx, vy, tvx, tvy, dv;
        longint unsigned d_len, ts, alen, sp;
        ax = 0;
        ay = 0;
        if (w.opcode == sfa_pkg::OPCODE_LOAD) begin
            ag_px = longint'(w.lpx);
            ag_py = longint'(w.lpy);
            ag_vx = longint'(w.lvx);
            ag_vy = longint'(w.lvy);
        end else begin
            dt = longint'(w.dt);
            dx = sat_q(longint'(w.tgt_x) - ag_px);
            dy = sat_q(longint'(w.tgt_y) - ag_py);
            d_len = magnitude(dx, dy);
            case (ag_mode)
                sfa_pkg::MODE_SEEK: rescale(dx, dy, d_len, ag_max_accel, ax, ay);
                sfa_pkg::MODE_FLEE: rescale(-dx, -dy, d_len, ag_max_accel, ax, ay);
                sfa_pkg::MODE_ARRIVE: begin
                    dv = (ag_ttt != 0) ? longint'(ag_ttt) : 1;
                    if (d_len < ag_tgt_radius) ts = 0;
                    else if (d_len > ag_slow_radius) ts = ag_max_speed;
                    else if (ag_slow_radius == 0) ts = 0;
                    else ts = ag_max_speed * d_len / ag_slow_radius;
                    rescale(dx, dy, d_len, ts, tvx, tvy);
                    ax = sat_q((tvx - ag_vx) * ONE_Q / dv);
                    ay = sat_q((tvy - ag_vy) * ONE_Q / dv);
                    alen = magnitude(ax, ay);
                    if (alen > ag_max_accel) rescale(ax, ay, alen, ag_max_accel, ax, ay);
                end
                default: ;
            endcase
            ag_px = sat_q(ag_px + ag_vx * dt / ONE_Q);
            ag_py = sat_q(ag_py + ag_vy * dt / ONE_Q);
            vx = sat_q(ag_vx + ax * dt / ONE_Q);
            vy = sat_q(ag_vy + ay * dt / ONE_Q);
            sp = magnitude(vx, vy);
            if (sp > ag_max_speed) begin
                rescale(vx, vy, sp, ag_max_speed, vx, vy);
                sp = magnitude(vx, vy);
            end
            if (sp < ag_stop_speed) begin
                vx = 0;
                vy = 0;
            end
            ag_vx = vx;
            ag_vy = vy;
        end
        res[0] = ag_px[31:0];
        res[1] = ag_py[31:0];
        res[2] = ag_vx[31:0];
        res[3] = ag_vy[31:0];
        res[4] = ax[31:0];
        res[5] = ay[31:0];
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [30:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sfa_pkg::CFG_STEER_MODE:     ag_mode = sfa_pkg::t_mode'(data[1:0]);
            sfa_pkg::CFG_MAX_SPEED:      ag_max_speed = 64'(data);
            sfa_pkg::CFG_MAX_ACCEL:      ag_max_accel = 64'(data);
            sfa_pkg::CFG_TARGET_RADIUS:  ag_tgt_radius = 64'(data);
            sfa_pkg::CFG_SLOW_RADIUS:    ag_slow_radius = 64'(data);
            sfa_pkg::CFG_TIME_TO_TARGET: ag_ttt = 64'(data);
            sfa_pkg::CFG_STOP_SPEED:     ag_stop_speed = 64'(data);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_word(input t_word w);
        t_agent_out res;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= w.opcode;
        i_target_x   <= w.tgt_x;
        i_target_y   <= w.tgt_y;
        i_delta_time <= w.dt;
        i_load_pos_x <= w.lpx;
        i_load_pos_y <= w.lpy;
        i_load_vel_x <= w.lvx;
        i_load_vel_y <= w.lvy;
        do @(posedge i_clk); while (o_in_stall);
        step_agent(w, res);
        expected_states = {expected_states, res};
    endtask

    // drain all results before touching the registers
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_word load_word(input longint px, input longint py,
                                        input longint vx, input longint vy);
        t_word w;
        w = '{default: '0};
        w.opcode = sfa_pkg::OPCODE_LOAD;
        w.lpx = px[31:0];
        w.lpy = py[31:0];
        w.lvx = vx[31:0];
        w.lvy = vy[31:0];
        w.tgt_x = $urandom;
        w.tgt_y = $urandom;
        w.dt = 31'($urandom);
        return w;
    endfunction

    function automatic t_word tick_word(input longint tx, input longint ty, input longint dt);
        t_word w;
        w.opcode = ~sfa_pkg::OPCODE_LOAD;
        w.tgt_x = tx[31:0];
        w.tgt_y = ty[31:0];
        w.dt = dt[30:0];
        w.lpx = $urandom;
        w.lpy = $urandom;
        w.lvx = $urandom;
        w.lvy = $urandom;
        return w;
    endfunction

    function automatic logic [30:0] cfg_value();
        case ($urandom_range(7))
            0: return '0;
            1: return 31'h7fffffff;
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 20 * 65536));
        endcase
    endfunction

    function automatic longint near(input longint span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_idle);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_agent_out got;
        t_agent_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_accel_y, o_accel_x, o_out_vel_y, o_out_vel_x, o_out_pos_y, o_out_pos_x};
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
            end else begin
                want = expected_states.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== want[k]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s mismatch: expected %h got %h", field_names[k],
                                     want[k], got[k]);
                    end
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_word(tick_word(0, 0, ONE_Q));
        send_word(tick_word(20 * ONE_Q, -5 * ONE_Q, ONE_Q));
        send_word(tick_word(3 * ONE_Q, 1 * ONE_Q, ONE_Q / 2));
        send_word(load_word(64'sh7fffffff, -64'sh80000000, 64'sh7fffffff, -64'sh80000000));
        send_word(tick_word(-64'sh80000000, 64'sh7fffffff, 64'h7fffffff));
        send_word(load_word(0, 0, 3 * ONE_Q, 4 * ONE_Q));
        send_word(tick_word(0, 0, 0));
        settle();
    endtask

    task automatic test_each_mode();
        for (int m = 0; m < 4; m++) begin
            cfg_write(sfa_pkg::CFG_STEER_MODE, 31'(m));
            send_word(load_word(ONE_Q, -2 * ONE_Q, ONE_Q, 0));
            send_word(tick_word(6 * ONE_Q, 2 * ONE_Q, ONE_Q));
            send_word(tick_word(ONE_Q, -2 * ONE_Q, ONE_Q));
            send_word(tick_word(64'sh7fffffff, -64'sh80000000, 64'h7fffffff));
            settle();
        end
    endtask

    task automatic test_arrive_corners();
        cfg_write(sfa_pkg::CFG_STEER_MODE, 31'(sfa_pkg::MODE_ARRIVE));
        cfg_write(sfa_pkg::CFG_TIME_TO_TARGET, 31'd0);
        cfg_write(sfa_pkg::CFG_SLOW_RADIUS, 31'd0);
        cfg_write(sfa_pkg::CFG_TARGET_RADIUS, 31'(2 * ONE_Q));
        cfg_write(sfa_pkg::CFG_STOP_SPEED, 31'(ONE_Q));
        cfg_write(CFG_UNUSED_IDX, 31'h55555555);
        send_word(load_word(0, 0, ONE_Q / 4, 0));
        send_word(tick_word(ONE_Q, 0, ONE_Q));
        send_word(tick_word(0, 0, ONE_Q));
        send_word(tick_word(9 * ONE_Q, 9 * ONE_Q, ONE_Q));
        settle();
        cfg_write(sfa_pkg::CFG_MAX_SPEED, 31'h7fffffff);
        cfg_write(sfa_pkg::CFG_MAX_ACCEL, 31'h7fffffff);
        send_word(tick_word(-64'sh80000000, -64'sh80000000, 64'h7fffffff));
        settle();
    endtask

    task automatic test_random(input int n, input int s_idle, input int r_idle);
        t_word w;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) begin
                settle();
                cfg_write(sfa_pkg::CFG_STEER_MODE, 31'($urandom_range(3)));
                for (int r = sfa_pkg::CFG_MAX_SPEED; r <= sfa_pkg::CFG_STOP_SPEED; r++) begin
                    cfg_write(r[2:0], cfg_value());
                end
            end
            case ($urandom_range(9))
                0: begin
                    w = tick_word(0, 0, 0);
                    w.opcode = 1'($urandom);
                    w.lpx = $urandom;
                    w.lpy = $urandom;
                    w.lvx = $urandom;
                    w.lvy = $urandom;
                    w.tgt_x = $urandom;
                    w.tgt_y = $urandom;
                end
                1: w = load_word(near(100 * ONE_Q), near(100 * ONE_Q),
                                 near(10 * ONE_Q), near(10 * ONE_Q));
                default: w = tick_word(sat_q(ag_px + near(40 * ONE_Q)),
                                       sat_q(ag_py + near(40 * ONE_Q)),
                                       $urandom_range(2 * ONE_Q));
            endcase
            send_word(w);
        end
        settle();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_out_stall  = 1'b0;
        i_opcode     = 1'b0;
        i_target_x   = '0;
        i_target_y   = '0;
        i_delta_time = '0;
        i_load_pos_x = '0;
        i_load_pos_y = '0;
        i_load_vel_x = '0;
        i_load_vel_y = '0;
        ag_mode        = sfa_pkg::MODE_ARRIVE;
        ag_max_speed   = 524288;
        ag_max_accel   = 131072;
        ag_tgt_radius  = 0;
        ag_slow_radius = 655360;
        ag_ttt         = 65536;
        ag_stop_speed  = 0;
        ag_px = 0;
        ag_py = 0;
        ag_vx = 0;
        ag_vy = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_each_mode();
        test_arrive_corners();
        test_random(475, 35, 72);
        test_random(475, 72, 35);
        test_random(475, 0, 0);

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
